/* hw/rtl/sha256_pkg.sv */
package sha256_pkg;

    typedef logic [0:7][31:0] hash_t;

    localparam hash_t IV_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_FINAL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        BSEL_MSG,
        BSEL_PAD,
        BSEL_ZERO,
        BSEL_LEN
    } byte_sel_t;

    typedef struct packed {
        logic      shift_en;
        byte_sel_t byte_sel;
        logic      count_en;
        logic      load_len;
        logic      comp_start;
        logic      round_en;
        logic [5:0] rnd;
        logic      final_add;
        logic      out_shift;
        logic      reinit;
    } dp_cmd_t;

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] r);
        logic [31:0] k;
        case (r)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

/* hw/rtl/sha256_ctrl.sv */
module sha256_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 action,
    input  logic                 m_tready,
    output logic                 s_tready,
    output logic                 m_tvalid,
    output logic                 m_tlast,
    output logic [2:0]           word_idx,
    output sha256_pkg::dp_cmd_t  cmd
);

    sha256_pkg::state_t state_reg, state_next;
    sha256_pkg::state_t ret_reg, ret_next;
    logic [5:0] fill_reg, fill_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [2:0] idx_reg, idx_next;
    logic       pad_first_reg, pad_first_next;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (action) begin
                        state_next = sha256_pkg::ST_PAD;
                    end else if (fill_reg == 6'd63) begin
                        state_next = sha256_pkg::ST_COMP;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                if (fill_reg == 6'd55) begin
                    state_next = sha256_pkg::ST_LEN;
                end else if (fill_reg == 6'd63) begin
                    state_next = sha256_pkg::ST_COMP;
                end
            end
            sha256_pkg::ST_LEN: begin
                if (fill_reg == 6'd63) begin
                    state_next = sha256_pkg::ST_COMP;
                end
            end
            sha256_pkg::ST_COMP: begin
                if (rnd_reg == 6'd63) begin
                    state_next = sha256_pkg::ST_FINAL;
                end
            end
            sha256_pkg::ST_FINAL: begin
                state_next = ret_reg;
            end
            sha256_pkg::ST_OUT: begin
                if (m_tready && idx_reg == 3'd7) begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        s_tready       = 1'b0;
        m_tvalid       = 1'b0;
        m_tlast        = 1'b0;
        cmd            = '0;
        cmd.byte_sel   = sha256_pkg::BSEL_ZERO;
        cmd.rnd        = rnd_reg;
        unique case (state_reg)
            sha256_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && !action) begin
                    cmd.shift_en   = 1'b1;
                    cmd.byte_sel   = sha256_pkg::BSEL_MSG;
                    cmd.count_en   = 1'b1;
                    cmd.comp_start = (fill_reg == 6'd63);
                end
                if (s_tvalid && action) begin
                    cmd.load_len = 1'b1;
                end
            end
            sha256_pkg::ST_PAD: begin
                cmd.shift_en   = 1'b1;
                cmd.byte_sel   = pad_first_reg ? sha256_pkg::BSEL_PAD : sha256_pkg::BSEL_ZERO;
                cmd.comp_start = (fill_reg == 6'd63);
            end
            sha256_pkg::ST_LEN: begin
                cmd.shift_en   = 1'b1;
                cmd.byte_sel   = sha256_pkg::BSEL_LEN;
                cmd.comp_start = (fill_reg == 6'd63);
            end
            sha256_pkg::ST_COMP: begin
                cmd.round_en = 1'b1;
            end
            sha256_pkg::ST_FINAL: begin
                cmd.final_add = 1'b1;
            end
            sha256_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
                m_tlast  = (idx_reg == 3'd7);
                if (m_tready) begin
                    cmd.out_shift = 1'b1;
                    cmd.reinit    = (idx_reg == 3'd7);
                end
            end
            default: ;
        endcase
    end

    // counters and flags
    always_comb begin
        fill_next      = cmd.shift_en ? fill_reg + 6'd1 : fill_reg;
        rnd_next       = cmd.round_en ? rnd_reg + 6'd1 : 6'd0;
        idx_next       = cmd.out_shift ? idx_reg + 3'd1 : idx_reg;
        pad_first_next = pad_first_reg;
        ret_next       = ret_reg;
        if (cmd.load_len) begin
            pad_first_next = 1'b1;
        end else if (state_reg == sha256_pkg::ST_PAD) begin
            pad_first_next = 1'b0;
        end
        if (cmd.comp_start) begin
            case (state_reg)
                sha256_pkg::ST_PAD: ret_next = sha256_pkg::ST_PAD;
                sha256_pkg::ST_LEN: ret_next = sha256_pkg::ST_OUT;
                default:            ret_next = sha256_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sha256_pkg::ST_IDLE;
            ret_reg       <= sha256_pkg::ST_IDLE;
            fill_reg      <= '0;
            rnd_reg       <= '0;
            idx_reg       <= '0;
            pad_first_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            rnd_reg       <= rnd_next;
            idx_reg       <= idx_next;
            pad_first_reg <= pad_first_next;
        end
    end

    assign word_idx = idx_reg;

endmodule

/* hw/rtl/sha256_dpath.sv */
module sha256_dpath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sha256_pkg::dp_cmd_t  cmd,
    input  logic [7:0]           data_byte,
    output logic [31:0]          digest_word
);

    // block window: byte shift on load, word shift as message schedule
    logic [511:0]       blk_reg, blk_next;
    sha256_pkg::hash_t  v_reg, v_next;
    sha256_pkg::hash_t  chain_reg, chain_next;
    logic [60:0]        cnt_reg, cnt_next;
    logic [63:0]        len_reg, len_next;

    logic [7:0]  in_byte;
    logic [31:0] w0, w1, w9, w14, w_new;
    logic [31:0] t1, t2, ch, maj;

    assign w0  = blk_reg[511:480];
    assign w1  = blk_reg[479:448];
    assign w9  = blk_reg[223:192];
    assign w14 = blk_reg[63:32];
    assign w_new = sha256_pkg::small_s1(w14) + w9 + sha256_pkg::small_s0(w1) + w0;

    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1  = v_reg[7] + sha256_pkg::big_s1(v_reg[4]) + ch
               + sha256_pkg::round_k(cmd.rnd) + w0;
    assign t2  = sha256_pkg::big_s0(v_reg[0]) + maj;

    always_comb begin
        case (cmd.byte_sel)
            sha256_pkg::BSEL_MSG: in_byte = data_byte;
            sha256_pkg::BSEL_PAD: in_byte = sha256_pkg::PAD_BYTE;
            sha256_pkg::BSEL_LEN: in_byte = len_reg[63:56];
            default:              in_byte = 8'h00;
        endcase
    end

    always_comb begin
        blk_next   = blk_reg;
        v_next     = v_reg;
        chain_next = chain_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;

        if (cmd.shift_en) begin
            blk_next = {blk_reg[503:0], in_byte};
        end else if (cmd.round_en) begin
            blk_next = {blk_reg[479:0], w_new};
        end

        if (cmd.comp_start) begin
            v_next = chain_reg;
        end else if (cmd.round_en) begin
            v_next = {t1 + t2, v_reg[0], v_reg[1], v_reg[2],
                      v_reg[3] + t1, v_reg[4], v_reg[5], v_reg[6]};
        end

        if (cmd.reinit) begin
            chain_next = sha256_pkg::IV_INIT;
        end else if (cmd.final_add) begin
            for (int i = 0; i < 8; i++) begin
                chain_next[i] = chain_reg[i] + v_reg[i];
            end
        end else if (cmd.out_shift) begin
            chain_next = {chain_reg[1:7], 32'h0};
        end

        if (cmd.reinit) begin
            cnt_next = '0;
        end else if (cmd.count_en) begin
            cnt_next = cnt_reg + 61'd1;
        end

        if (cmd.load_len) begin
            len_next = {cnt_reg, 3'b000};
        end else if (cmd.shift_en && cmd.byte_sel == sha256_pkg::BSEL_LEN) begin
            len_next = {len_reg[55:0], 8'h00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= sha256_pkg::IV_INIT;
            cnt_reg   <= '0;
        end else begin
            chain_reg <= chain_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg <= blk_next;
        v_reg   <= v_next;
        len_reg <= len_next;
    end

    assign digest_word = chain_reg[0];

endmodule

/* hw/rtl/sha256_hash_engine_top.sv */
// Absorb word: accepted while idle; every 64th message byte also starts a block
//   compression (64 rounds, then the chain add), s_tready low meanwhile.
// Finish word: byte-serial padding up to the length field (with a compressed spill
//   block if the pad byte lands past byte 55), 8 length bytes, final compression,
//   then 8 digest words, one per cycle while m_tready is high.
// Reset (aresetn low, synchronous): idle, empty message, initial hash values.
module sha256_hash_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] action: 0 absorb, 1 finish
    // digest channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);

    sha256_pkg::dp_cmd_t cmd;
    logic [2:0]          word_idx;
    logic [31:0]         digest_word;

    // sequencing: absorb, pad, length, rounds, digest drain
    sha256_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .action   (s_tuser[0]),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tlast  (m_tlast),
        .word_idx (word_idx),
        .cmd      (cmd)
    );

    // block window, round state, chaining words, length counter
    sha256_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .data_byte   (s_tdata),
        .digest_word (digest_word)
    );

    // digest word comes straight off chain register 0, which shifts per word
    assign m_tdata = {5'b00000, word_idx, digest_word};

    // never take input while digest words are pending
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_tready && m_tvalid))
        else $error("input accepted during digest output");

    // digest words go out in order without gaps
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("digest word order broken");

    // after the final digest word the engine is back to absorbing
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("engine not idle after digest");

endmodule

/* sim/sha256_hash_engine_top_tb.sv */
`timescale 1ns / 1ps

module sha256_hash_engine_top_tb;

    localparam bit ACT_ABSORB = 1'b0;
    localparam bit ACT_FINISH = 1'b1;

    localparam int RANDOM_ITEMS   = 500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    localparam bit [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        is_last;
    } digest_beat_t;

    // Hash predictor plus queue of digest words still owed by the block.
    class digest_scoreboard;
        bit [31:0]    chain [8];
        bit [7:0]     msg_block [64];
        int unsigned  fill;
        bit [63:0]    msg_bits;
        digest_beat_t owed_words [$];
        int           errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) chain[i] = sha256_pkg::IV_INIT[i];
            for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
            fill     = 0;
            msg_bits = 64'd0;
        endfunction

        function bit [31:0] ror(bit [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            bit [31:0] w [64];
            bit [31:0] v [8];
            bit [31:0] t1, t2, e, a;
            for (int r = 0; r < 16; r++)
                w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
            for (int r = 16; r < 64; r++)
                w[r] = (ror(w[r-2], 17) ^ ror(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
                     + (ror(w[r-15], 7) ^ ror(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
            for (int i = 0; i < 8; i++) v[i] = chain[i];
            for (int r = 0; r < 64; r++) begin
                e  = v[4];
                a  = v[0];
                t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
                   + ((e & v[5]) ^ (~e & v[6])) + ROUND_CONST[r] + w[r];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
                   + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        function void note_input(bit action, bit [7:0] data_byte);
            bit [63:0]    total;
            digest_beat_t beat;
            if (action == ACT_ABSORB) begin
                msg_block[fill] = data_byte;
                fill++;
                if (fill == 64) begin
                    compress();
                    msg_bits += 64'd512;
                    fill = 0;
                end
            end else begin
                total = msg_bits + 64'(fill * 8);
                msg_block[fill] = sha256_pkg::PAD_BYTE;
                for (int i = fill + 1; i < 64; i++) msg_block[i] = 8'h00;
                // no room for the length field: spill into one more block
                if (fill >= 56) begin
                    compress();
                    for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
                end
                for (int i = 0; i < 8; i++) msg_block[63-i] = total[8*i +: 8];
                compress();
                for (int i = 0; i < 8; i++) begin
                    beat.digest_word = chain[i];
                    beat.word_index  = 3'(i);
                    beat.is_last     = (i == 7);
                    owed_words.push_back(beat);
                end
                restart();
            end
        endfunction

        function void check_result(digest_beat_t got);
            digest_beat_t want;
            if (owed_words.size() == 0) begin
                errors++;
                $display("%0t: unexpected word: expected none, got %h idx %0d last %0b",
                         $time, got.digest_word, got.word_index, got.is_last);
            end else begin
                want = owed_words.pop_front();
                if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
                    got.is_last !== want.is_last) begin
                    errors++;
                    $display("%0t: mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                             $time, want.digest_word, want.word_index, want.is_last,
                             got.digest_word, got.word_index, got.is_last);
                end
            end
        endfunction

        function int pending();
            return owed_words.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;

    digest_scoreboard sb;
    int sender_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int quiet_cycles;

    sha256_hash_engine_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver backpressure, redrawn every cycle
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: feed accepted words to the predictor, check digest words, watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_input(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result('{m_tdata[31:0], m_tdata[34:32], m_tlast});
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // one input word; optional idle gap first, returns once the word is taken
    task automatic send_word(input bit action, input bit [7:0] data_byte);
        @(negedge aclk);
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= action;
        s_tdata  <= data_byte;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // message lengths lean toward the padding and block boundaries
    function automatic int pick_msg_len();
        int edges [12] = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        case ($urandom_range(9))
            0, 1, 2, 3: return $urandom_range(20);
            4, 5:       return $urandom_range(70, 21);
            9:          return $urandom_range(140, 100);
            default:    return edges[$urandom_range(11)];
        endcase
    endfunction

    initial begin
        int msg_len;
        sb              = new();
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = 8'h00;
        s_tuser         = ACT_ABSORB;
        m_tready        = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        items_sent      = 0;
        quiet_cycles    = 0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty message twice (reinit after finish), byte extremes, "abc"
        send_word(ACT_FINISH, 8'h00);
        send_word(ACT_FINISH, 8'hff);
        send_word(ACT_ABSORB, 8'h00);
        send_word(ACT_FINISH, 8'h00);
        send_word(ACT_ABSORB, 8'hff);
        send_word(ACT_FINISH, 8'h5a);
        send_word(ACT_ABSORB, 8'h61);
        send_word(ACT_ABSORB, 8'h62);
        send_word(ACT_ABSORB, 8'h63);
        send_word(ACT_FINISH, 8'h00);

        // random messages over four pacing phases
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            case (items_sent * 4 / RANDOM_ITEMS)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin sender_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            msg_len = pick_msg_len();
            repeat (msg_len) send_word(ACT_ABSORB, 8'($urandom_range(255)));
            send_word(ACT_FINISH, 8'($urandom_range(255)));
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/sha256_pkg.sv
hw/rtl/sha256_ctrl.sv
hw/rtl/sha256_dpath.sv
hw/rtl/sha256_hash_engine_top.sv
sim/sha256_hash_engine_top_tb.sv
